// ===== design/psm_pkg.sv =====
package psm_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int CW_EFF = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

    typedef struct packed {
        logic [1:0]         slot;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [31:0] coord_w;
    } t_req;

    typedef struct packed {
        logic [1:0]         row;
        logic signed [63:0] col0;
        logic signed [63:0] col1;
        logic signed [63:0] col2;
        logic signed [63:0] col3;
        logic               last;
    } t_res;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_rd_ctl;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } t_rd_rsp;

    // two's complement in the low CW_EFF bits
    function automatic logic signed [31:0] take_coord(input logic signed [31:0] v);
        logic signed [31:0] t;
        t = v <<< (32 - CW_EFF);
        return t >>> (32 - CW_EFF);
    endfunction

endpackage

// ===== design/psm_rdiv.sv =====
module psm_rdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psm_pkg::t_rd_ctl  i_ctl,
    input  logic [63:0]       i_rad,
    input  logic [29:0]       i_mag,
    input  logic [31:0]       i_den,
    output psm_pkg::t_rd_rsp  o_rsp
);
    import psm_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic        r_isdiv;
    logic [4:0]  r_cnt;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [31:0] r_rem;
    logic [31:0] r_num;
    logic [31:0] r_q;
    logic [31:0] r_den;

    logic [63:0] w_bit;
    logic [63:0] w_rb;
    logic [32:0] w_t;

    assign w_bit = 64'd1 << {r_cnt, 1'b0};
    assign w_rb  = r_r + w_bit;
    assign w_t   = {r_rem, r_num[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_ctl.start) begin
                r_busy  <= 1'b1;
                r_isdiv <= i_ctl.is_div;
                r_cnt   <= 5'd31;
                r_v     <= i_rad;
                r_r     <= 64'd0;
                r_rem   <= {4'd0, i_mag[29:2]};
                r_num   <= {i_mag[1:0], 30'd0};
                r_q     <= 32'd0;
                r_den   <= i_den;
            end else if (r_busy) begin
                if (r_isdiv) begin
                    r_num <= {r_num[30:0], 1'b0};
                    if (w_t >= {1'b0, r_den}) begin
                        r_rem <= 32'(w_t - {1'b0, r_den});
                        r_q   <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rem <= w_t[31:0];
                        r_q   <= {r_q[30:0], 1'b0};
                    end
                end else begin
                    if (r_v >= w_rb) begin
                        r_v <= r_v - w_rb;
                        r_r <= (r_r >> 1) + w_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_isdiv ? r_q : r_r[31:0];

endmodule

// ===== design/planar_shadow_matrix_from_points.sv =====
// a light request (slot 3) runs the sequence and gives the four rows of the matrix; the time
// to the last row is set by how many shifts bring the differences and the cross product into range
// rows 0..3 come in order, each strobed once
// point requests (slots 0..2) are stored while idle and give no result
// busy until the fourth row, so a new light request is taken only after the last row
// reset (synchronous, active low) clears the stored points and the sequencer
module planar_shadow_matrix_from_points (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  psm_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_valid,
    output psm_pkg::t_res o_res
);
    import psm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FITEF = 4'd1;
    localparam logic [3:0] S_CROSS = 4'd2;
    localparam logic [3:0] S_FITC  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_DOT   = 4'd8;
    localparam logic [3:0] S_ENT   = 4'd9;

    logic [3:0]         r_state;
    logic               r_ph;
    logic [2:0]         r_j;
    logic [1:0]         r_row;
    logic [1:0]         r_col;
    logic signed [31:0] r_pt [0:8];
    logic signed [31:0] r_lt [0:3];
    logic signed [32:0] r_e [0:2];
    logic signed [32:0] r_f [0:2];
    logic signed [61:0] r_c [0:2];
    logic signed [31:0] r_pl [0:2];
    logic signed [47:0] r_d;
    logic [31:0]        r_len;
    logic signed [95:0] r_acc;
    logic signed [95:0] r_dot;
    logic signed [65:0] r_prod;
    logic signed [63:0] r_ent [0:2];
    logic               r_valid;
    t_res               r_res;

    logic signed [32:0] w_a;
    logic signed [32:0] w_b;
    logic               w_neg;
    logic               w_sh;
    logic               w_first;
    logic               w_last;
    logic signed [95:0] w_init;
    logic signed [95:0] w_sp;
    logic signed [95:0] n_acc;
    logic signed [95:0] w_shr;
    logic signed [63:0] w_sat;
    logic signed [95:0] w_negsum;
    logic signed [31:0] w_prow;
    logic signed [32:0] w_dlo;
    logic signed [32:0] w_dhi;
    logic signed [61:0] w_cj;
    logic [61:0]        w_cmag;
    logic               w_bige;
    logic               w_bigf;
    logic               w_bigc;
    t_rd_ctl            w_ctl;
    t_rd_rsp            w_rsp;

    function automatic logic too_big(input logic signed [61:0] x);
        return (x >= 62'sd1073741824) || (x <= -62'sd1073741824);
    endfunction

    assign w_bige = too_big(62'(r_e[0])) || too_big(62'(r_e[1])) || too_big(62'(r_e[2]));
    assign w_bigf = too_big(62'(r_f[0])) || too_big(62'(r_f[1])) || too_big(62'(r_f[2]));
    assign w_bigc = too_big(r_c[0]) || too_big(r_c[1]) || too_big(r_c[2]);

    assign w_dlo  = {9'd0, r_d[23:0]};
    assign w_dhi  = 33'($signed(r_d[47:24]));
    assign w_prow = (r_row == 2'd0) ? r_pl[0] : (r_row == 2'd1) ? r_pl[1] : r_pl[2];
    assign w_cj   = (r_j[1:0] == 2'd0) ? r_c[0] : (r_j[1:0] == 2'd1) ? r_c[1] : r_c[2];
    assign w_cmag = w_cj[61] ? 62'(-w_cj) : w_cj;

    // operand selection for the shared multiplier
    always_comb begin
        w_a     = '0;
        w_b     = '0;
        w_neg   = 1'b0;
        w_sh    = 1'b0;
        w_first = 1'b0;
        w_last  = 1'b0;
        w_init  = '0;
        case (r_state)
            S_CROSS: begin
                w_first = ~r_j[0];
                w_last  = r_j[0];
                w_neg   = r_j[0];
                case (r_j)
                    3'd0: begin w_a = r_e[1]; w_b = r_f[2]; end
                    3'd1: begin w_a = r_e[2]; w_b = r_f[1]; end
                    3'd2: begin w_a = r_e[2]; w_b = r_f[0]; end
                    3'd3: begin w_a = r_e[0]; w_b = r_f[2]; end
                    3'd4: begin w_a = r_e[0]; w_b = r_f[1]; end
                    default: begin w_a = r_e[1]; w_b = r_f[0]; end
                endcase
            end
            S_SQ: begin
                w_first = (r_j == 3'd0);
                w_last  = (r_j == 3'd2);
                w_a     = 33'(w_cj);
                w_b     = 33'(w_cj);
            end
            S_SUM: begin
                w_first = (r_j == 3'd0);
                w_last  = (r_j == 3'd2);
                case (r_j)
                    3'd0: begin w_a = 33'(r_pl[0]); w_b = 33'(r_pt[6]); end
                    3'd1: begin w_a = 33'(r_pl[1]); w_b = 33'(r_pt[7]); end
                    default: begin w_a = 33'(r_pl[2]); w_b = 33'(r_pt[8]); end
                endcase
            end
            S_DOT: begin
                w_first = (r_j == 3'd0);
                w_last  = (r_j == 3'd4);
                case (r_j)
                    3'd0: begin w_a = 33'(r_pl[0]); w_b = 33'(r_lt[0]); end
                    3'd1: begin w_a = 33'(r_pl[1]); w_b = 33'(r_lt[1]); end
                    3'd2: begin w_a = 33'(r_pl[2]); w_b = 33'(r_lt[2]); end
                    3'd3: begin w_a = w_dlo; w_b = 33'(r_lt[3]); end
                    default: begin w_a = w_dhi; w_b = 33'(r_lt[3]); w_sh = 1'b1; end
                endcase
            end
            S_ENT: begin
                w_neg  = 1'b1;
                w_init = (r_row == r_col) ? r_dot : '0;
                w_b    = 33'(r_lt[r_col]);
                if (r_row == 2'd3) begin
                    w_first = ~r_j[0];
                    w_last  = r_j[0];
                    w_sh    = r_j[0];
                    w_a     = r_j[0] ? w_dhi : w_dlo;
                end else begin
                    w_first = 1'b1;
                    w_last  = 1'b1;
                    w_a     = 33'(w_prow);
                end
            end
            default: ;
        endcase
    end

    assign w_sp     = 96'(r_prod) <<< (w_sh ? 24 : 0);
    assign n_acc    = (w_first ? w_init : r_acc) + (w_neg ? -w_sp : w_sp);
    assign w_shr    = n_acc >>> 14;
    assign w_sat    = ((&w_shr[95:63]) || !(|w_shr[95:63])) ? w_shr[63:0] :
                      (n_acc[95] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});
    assign w_negsum = -n_acc;

    assign w_ctl.start  = ((r_state == S_SQRT) || (r_state == S_DIV)) && !r_ph;
    assign w_ctl.is_div = (r_state == S_DIV);

    psm_rdiv u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rad   (r_acc[63:0]),
        .i_mag   (w_cmag[29:0]),
        .i_den   (r_len),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_j     <= 3'd0;
            r_row   <= 2'd0;
            r_col   <= 2'd0;
            r_valid <= 1'b0;
            for (int i = 0; i < 9; i++) r_pt[i] <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_req.slot == 2'd3) begin
                            r_lt[0] <= take_coord(i_req.coord_x);
                            r_lt[1] <= take_coord(i_req.coord_y);
                            r_lt[2] <= take_coord(i_req.coord_z);
                            r_lt[3] <= take_coord(i_req.coord_w);
                            for (int i = 0; i < 3; i++) begin
                                r_e[i] <= 33'(r_pt[i]) - 33'(r_pt[3+i]);
                                r_f[i] <= 33'(r_pt[3+i]) - 33'(r_pt[6+i]);
                            end
                            r_state <= S_FITEF;
                        end else begin
                            r_pt[{2'd0, i_req.slot} * 4'd3]        <= take_coord(i_req.coord_x);
                            r_pt[{2'd0, i_req.slot} * 4'd3 + 4'd1] <= take_coord(i_req.coord_y);
                            r_pt[{2'd0, i_req.slot} * 4'd3 + 4'd2] <= take_coord(i_req.coord_z);
                        end
                    end
                end
                S_FITEF: begin
                    for (int i = 0; i < 3; i++) begin
                        if (w_bige) r_e[i] <= r_e[i] >>> 1;
                        if (w_bigf) r_f[i] <= r_f[i] >>> 1;
                    end
                    if (!w_bige && !w_bigf) begin
                        r_state <= S_CROSS;
                        r_j     <= 3'd0;
                        r_ph    <= 1'b0;
                    end
                end
                S_FITC: begin
                    for (int i = 0; i < 3; i++) begin
                        if (w_bigc) r_c[i] <= r_c[i] >>> 1;
                    end
                    if (!w_bigc) begin
                        r_state <= S_SQ;
                        r_j     <= 3'd0;
                    end
                end
                S_SQRT: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_len   <= (w_rsp.value == 32'd0) ? 32'd1 : w_rsp.value;
                        r_ph    <= 1'b0;
                        r_j     <= 3'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_pl[r_j[1:0]] <= w_cj[61] ? -$signed(w_rsp.value) : $signed(w_rsp.value);
                        r_ph <= 1'b0;
                        if (r_j == 3'd2) begin
                            r_j     <= 3'd0;
                            r_state <= S_SUM;
                        end else begin
                            r_j <= r_j + 3'd1;
                        end
                    end
                end
                S_CROSS, S_SQ, S_SUM, S_DOT, S_ENT: begin
                    if (!r_ph) begin
                        r_prod <= w_a * w_b;
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph  <= 1'b0;
                        r_acc <= n_acc;
                        r_j   <= r_j + 3'd1;
                        case (r_state)
                            S_CROSS: begin
                                if (w_last) r_c[r_j[2:1]] <= n_acc[61:0];
                                if (r_j == 3'd5) begin
                                    r_j     <= 3'd0;
                                    r_state <= S_FITC;
                                end
                            end
                            S_SQ: begin
                                if (w_last) begin
                                    r_j     <= 3'd0;
                                    r_state <= S_SQRT;
                                end
                            end
                            S_SUM: begin
                                if (w_last) begin
                                    r_d     <= 48'(w_negsum >>> 16);
                                    r_j     <= 3'd0;
                                    r_state <= S_DOT;
                                end
                            end
                            S_DOT: begin
                                if (w_last) begin
                                    r_dot   <= n_acc;
                                    r_j     <= 3'd0;
                                    r_row   <= 2'd0;
                                    r_col   <= 2'd0;
                                    r_state <= S_ENT;
                                end
                            end
                            default: begin
                                if (!w_last) begin
                                    r_j <= 3'd1;
                                end else begin
                                    r_j   <= 3'd0;
                                    r_col <= r_col + 2'd1;
                                    if (r_col != 2'd3) begin
                                        r_ent[r_col] <= w_sat;
                                    end else begin
                                        r_res.row  <= r_row;
                                        r_res.col0 <= r_ent[0];
                                        r_res.col1 <= r_ent[1];
                                        r_res.col2 <= r_ent[2];
                                        r_res.col3 <= w_sat;
                                        r_res.last <= (r_row == 2'd3);
                                        r_valid    <= 1'b1;
                                        r_row      <= r_row + 2'd1;
                                        if (r_row == 2'd3) r_state <= S_IDLE;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.last == (o_res.row == 2'd3)))
        else $error("last flag does not match row index");

    a_light_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_req.slot == 2'd3) |=> o_busy)
        else $error("light request did not start the sequence");

    a_point_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_req.slot != 2'd3) |=> (!o_busy && !o_valid))
        else $error("point request caused activity");

    a_mid_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.last) |-> o_busy)
        else $error("row strobed after the sequence ended");

endmodule
